>>> design/dsfc_pkg.sv
// Package for the dark scene fade controller: widths, constants, beat types,
// mode and sequencer encodings. No dependencies.
`default_nettype none
package dsfc_pkg;

  localparam int unsigned LumaW   = 12;
  localparam int unsigned DeltaW  = 20;
  localparam int unsigned TimeW   = 26;
  localparam int unsigned StrW    = 17;
  localparam int unsigned FracW   = 16;
  localparam int unsigned AccW    = LumaW + FracW;
  localparam int unsigned TimerW  = 32;
  localparam int unsigned CfgIdxW = 2;

  // serial divider: dividend is (delta << 16) + fade/2, divisor is fade
  localparam int unsigned DivNW   = DeltaW + FracW + 1;
  localparam int unsigned DivDW   = TimeW;
  localparam int unsigned DivCntW = $clog2(DivNW);

  localparam logic [StrW-1:0]   FullQ16      = 17'd65536;
  localparam logic [StrW-1:0]   SnapHigh     = 17'd65530;
  localparam logic [StrW-1:0]   SnapLow      = 17'd6;
  localparam logic [13:0]       SmoothW      = 14'd11796;
  localparam logic [DeltaW-1:0] DefaultDelta = 20'd16667;
  localparam logic [TimeW-1:0]  MinFade      = 26'd100;
  localparam logic [AccW-1:0]   AccReset     = {12'd4095, 16'd0};

  localparam logic [LumaW-1:0]  ThreshReset  = 12'd1228;
  localparam logic [TimeW-1:0]  HoldReset    = 26'd1000000;
  localparam logic [TimeW-1:0]  FadeInReset  = 26'd500000;
  localparam logic [TimeW-1:0]  FadeOutReset = 26'd500000;

  typedef enum logic [2:0] {
    MODE_IDLE   = 3'd0,
    MODE_WAIT   = 3'd1,
    MODE_FIN    = 3'd2,
    MODE_ACTIVE = 3'd3,
    MODE_FOUT   = 3'd4
  } mode_e;

  typedef enum logic [2:0] {
    SEQ_IDLE,
    SEQ_MUL,
    SEQ_ACC,
    SEQ_TIME,
    SEQ_DIV,
    SEQ_UPD
  } seq_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_THRESH   = 2'd0,
    CFG_HOLD     = 2'd1,
    CFG_FADE_IN  = 2'd2,
    CFG_FADE_OUT = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [LumaW-1:0] dark_threshold;
    logic [TimeW-1:0] hold_time_us;
    logic [TimeW-1:0] fade_in_us;
    logic [TimeW-1:0] fade_out_us;
  } cfg_t;

  typedef struct packed {
    logic [DeltaW-1:0] delta_us;
    logic [LumaW-1:0]  frame_luma;
  } in_beat_t;

  typedef struct packed {
    logic [StrW-1:0]  strength;
    logic [2:0]       mode;
    logic [LumaW-1:0] smoothed_luma;
    logic             dark_flag;
  } out_beat_t;

  typedef struct packed {
    logic             start;
    logic [DivNW-1:0] dividend;
    logic [DivDW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DivNW-1:0] quotient;
  } div_rsp_t;

endpackage
`default_nettype wire

>>> design/dsfc_div.sv
// Restoring serial divider, one quotient bit per cycle.
// Depends on dsfc_pkg for widths and the request/response structs.
`default_nettype none
module dsfc_div (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire dsfc_pkg::div_req_t req_i,
  output dsfc_pkg::div_rsp_t     rsp_o
);

  logic                         busy_q, busy_d;
  logic                         done_q, done_d;
  logic [dsfc_pkg::DivCntW-1:0] cnt_q, cnt_d;
  logic [dsfc_pkg::DivDW-1:0]   rem_q, rem_d;
  logic [dsfc_pkg::DivDW-1:0]   dsr_q, dsr_d;
  logic [dsfc_pkg::DivNW-1:0]   quo_q, quo_d;
  logic [dsfc_pkg::DivDW:0]     rem_sh;
  logic [dsfc_pkg::DivDW:0]     rem_sub;
  logic                         ge;

  assign rem_sh  = {rem_q, quo_q[dsfc_pkg::DivNW-1]};
  assign rem_sub = rem_sh - {1'b0, dsr_q};
  assign ge      = rem_sh >= {1'b0, dsr_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    quo_d  = quo_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      dsr_d  = req_i.divisor;
      quo_d  = req_i.dividend;
    end else if (busy_q) begin
      rem_d = ge ? rem_sub[dsfc_pkg::DivDW-1:0] : rem_sh[dsfc_pkg::DivDW-1:0];
      quo_d = {quo_q[dsfc_pkg::DivNW-2:0], ge};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == dsfc_pkg::DivCntW'(dsfc_pkg::DivNW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dsr_q <= dsr_d;
    quo_q <= quo_d;
  end

  assign rsp_o.busy     = busy_q;
  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule
`default_nettype wire

>>> design/dsfc_cfg.sv
// Configuration register file: threshold, hold time and fade times.
// Depends on dsfc_pkg for cfg_t, register indexes and reset values.
`default_nettype none
module dsfc_cfg (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [dsfc_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [dsfc_pkg::TimeW-1:0]     cfg_data_i,
  output dsfc_pkg::cfg_t                      cfg_o
);

  dsfc_pkg::cfg_t   cfg_q, cfg_d;
  dsfc_pkg::cfg_idx_e idx;

  assign idx         = dsfc_pkg::cfg_idx_e'(cfg_index_i);
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (idx)
        dsfc_pkg::CFG_THRESH:   cfg_d.dark_threshold = cfg_data_i[dsfc_pkg::LumaW-1:0];
        dsfc_pkg::CFG_HOLD:     cfg_d.hold_time_us   = cfg_data_i;
        dsfc_pkg::CFG_FADE_IN:  cfg_d.fade_in_us     = cfg_data_i;
        dsfc_pkg::CFG_FADE_OUT: cfg_d.fade_out_us    = cfg_data_i;
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dark_threshold <= dsfc_pkg::ThreshReset;
      cfg_q.hold_time_us   <= dsfc_pkg::HoldReset;
      cfg_q.fade_in_us     <= dsfc_pkg::FadeInReset;
      cfg_q.fade_out_us    <= dsfc_pkg::FadeOutReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

>>> design/dark_scene_fade_controller.sv
// Dark scene fade controller top level: sequencer, smoothing, timers, mode FSM.
// Depends on dsfc_pkg, dsfc_cfg and dsfc_div.
`default_nettype none
// One frame beat in, one result beat out. After acceptance a beat passes the
// multiply, accumulate and dark/timer update steps of the smoothing, then the
// serial divider (a load, then the quotient bits one by one)
// that forms the ramp step (delta * 65536 + fade / 2) / fade,
// then the mode update. The input is stalled for that whole
// time, so a new frame is not taken before the last one is through. A finished result
// sits in an output register, so the next frame can be taken while it waits;
// the mode update of that next frame holds until the earlier result has left.
// Configuration writes are always ready and act on the frame steps that read them after the write.
module dark_scene_fade_controller (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire dsfc_pkg::in_beat_t            in_data_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output dsfc_pkg::out_beat_t                out_data_o,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [dsfc_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [dsfc_pkg::TimeW-1:0]    cfg_data_i
);

  dsfc_pkg::cfg_t     cfg;
  dsfc_pkg::div_req_t div_req;
  dsfc_pkg::div_rsp_t div_rsp;

  dsfc_pkg::seq_e  seq_q, seq_d;
  dsfc_pkg::mode_e mode_q, mode_d;

  logic [dsfc_pkg::StrW-1:0]   str_q, str_d;
  logic [dsfc_pkg::AccW-1:0]   acc_q, acc_d;
  logic [dsfc_pkg::TimerW-1:0] dtime_q, dtime_d;
  logic [dsfc_pkg::TimerW-1:0] ltime_q, ltime_d;
  logic                        seen_q, seen_d;
  logic                        dark_q, dark_d;
  logic                        out_valid_q, out_valid_d;

  logic [dsfc_pkg::DeltaW-1:0] delta_q, delta_d;
  logic [dsfc_pkg::LumaW-1:0]  luma_q, luma_d;
  logic signed [43:0]          prod_q, prod_d;
  dsfc_pkg::out_beat_t         out_q, out_d;

  logic signed [28:0]          diff_s;
  logic signed [14:0]          wgt_s;
  logic signed [43:0]          mix_s;
  logic signed [28:0]          acc_sum;
  logic [dsfc_pkg::TimerW:0]   tsum;
  logic [dsfc_pkg::TimerW-1:0] tsat;
  logic [dsfc_pkg::TimeW-1:0]  fade_raw, fade;
  logic                        dark_met, light_met, hold_zero;
  logic [dsfc_pkg::DivNW:0]    fin_sum;
  logic [dsfc_pkg::StrW-1:0]   fin_s, fout_s;
  logic                        out_free;

  dsfc_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  dsfc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // smoothing: acc + round(11796 * ((luma << 16) - acc) / 65536)
  assign diff_s  = $signed({1'b0, luma_q, 16'd0}) - $signed({1'b0, acc_q});
  assign wgt_s   = $signed({1'b0, dsfc_pkg::SmoothW});
  assign prod_d  = diff_s * wgt_s;
  assign mix_s   = prod_q + 44'sd32768;
  assign acc_sum = $signed({1'b0, acc_q}) + $signed({mix_s[43], mix_s[43:16]});

  assign tsum = {1'b0, dark_q ? dtime_q : ltime_q} + 33'(delta_q);
  assign tsat = tsum[dsfc_pkg::TimerW] ? '1 : tsum[dsfc_pkg::TimerW-1:0];

  assign fade_raw = (mode_q == dsfc_pkg::MODE_FIN) ? cfg.fade_in_us : cfg.fade_out_us;
  assign fade     = (fade_raw < dsfc_pkg::MinFade) ? dsfc_pkg::MinFade : fade_raw;

  assign div_req.start    = (seq_q == dsfc_pkg::SEQ_TIME);
  assign div_req.dividend = {1'b0, delta_q, 16'd0} + dsfc_pkg::DivNW'(fade[dsfc_pkg::TimeW-1:1]);
  assign div_req.divisor  = fade;

  assign hold_zero = (cfg.hold_time_us == '0);
  assign dark_met  = hold_zero || (dtime_q >= 32'(cfg.hold_time_us));
  assign light_met = hold_zero || (ltime_q >= 32'(cfg.hold_time_us));

  assign fin_sum = 38'(str_q) + 38'(div_rsp.quotient);
  assign fin_s   = (fin_sum > 38'(dsfc_pkg::FullQ16)) ? dsfc_pkg::FullQ16
                                                      : fin_sum[dsfc_pkg::StrW-1:0];
  assign fout_s  = (37'(str_q) > div_rsp.quotient)
                 ? str_q - div_rsp.quotient[dsfc_pkg::StrW-1:0] : '0;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    seq_d       = seq_q;
    mode_d      = mode_q;
    str_d       = str_q;
    acc_d       = acc_q;
    dtime_d     = dtime_q;
    ltime_d     = ltime_q;
    seen_d      = seen_q;
    dark_d      = dark_q;
    delta_d     = delta_q;
    luma_d      = luma_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;

    unique case (seq_q)
      dsfc_pkg::SEQ_IDLE: begin
        if (in_valid_i) begin
          delta_d = (in_data_i.delta_us == '0) ? dsfc_pkg::DefaultDelta
                                               : in_data_i.delta_us;
          luma_d  = in_data_i.frame_luma;
          seq_d   = dsfc_pkg::SEQ_MUL;
        end
      end
      dsfc_pkg::SEQ_MUL: seq_d = dsfc_pkg::SEQ_ACC;
      dsfc_pkg::SEQ_ACC: begin
        if (!seen_q) begin
          acc_d  = {luma_q, 16'd0};
          seen_d = 1'b1;
        end else begin
          acc_d = acc_sum[dsfc_pkg::AccW-1:0];
        end
        seq_d = dsfc_pkg::SEQ_TIME;
      end
      dsfc_pkg::SEQ_TIME: begin
        dark_d = (acc_q <= {cfg.dark_threshold, 16'd0});
        seq_d  = dsfc_pkg::SEQ_DIV;
      end
      dsfc_pkg::SEQ_DIV: begin
        if (div_rsp.done) begin
          seq_d = dsfc_pkg::SEQ_UPD;
        end
      end
      dsfc_pkg::SEQ_UPD: begin
        if (out_free) begin
          unique case (mode_q)
            dsfc_pkg::MODE_WAIT: begin
              if (!dark_q) begin
                mode_d = dsfc_pkg::MODE_IDLE;
              end else if (dark_met) begin
                mode_d = dsfc_pkg::MODE_FIN;
              end
            end
            dsfc_pkg::MODE_FIN: begin
              if (!dark_q) begin
                if (light_met) mode_d = dsfc_pkg::MODE_FOUT;
              end else begin
                str_d = fin_s;
                if (fin_s >= dsfc_pkg::SnapHigh) begin
                  str_d  = dsfc_pkg::FullQ16;
                  mode_d = dsfc_pkg::MODE_ACTIVE;
                end
              end
            end
            dsfc_pkg::MODE_ACTIVE: begin
              str_d = dsfc_pkg::FullQ16;
              if (!dark_q && light_met) mode_d = dsfc_pkg::MODE_FOUT;
            end
            dsfc_pkg::MODE_FOUT: begin
              if (dark_q && dark_met) begin
                mode_d = dsfc_pkg::MODE_FIN;
              end else begin
                str_d = fout_s;
                if (fout_s <= dsfc_pkg::SnapLow) begin
                  str_d  = '0;
                  mode_d = dsfc_pkg::MODE_IDLE;
                end
              end
            end
            default: begin
              str_d  = '0;
              mode_d = !dark_q ? dsfc_pkg::MODE_IDLE
                     : (dark_met ? dsfc_pkg::MODE_FIN : dsfc_pkg::MODE_WAIT);
            end
          endcase
          out_d.strength      = str_d;
          out_d.mode          = mode_d;
          out_d.smoothed_luma = acc_q[dsfc_pkg::AccW-1:dsfc_pkg::FracW];
          out_d.dark_flag     = dark_q;
          out_valid_d         = 1'b1;
          seq_d               = dsfc_pkg::SEQ_IDLE;
        end
      end
      default: seq_d = dsfc_pkg::SEQ_IDLE;
    endcase

    // timers follow the fresh dark decision
    if (seq_q == dsfc_pkg::SEQ_TIME) begin
      if (dark_d) begin
        dtime_d = (dark_q == dark_d) ? tsat : 32'(delta_q);
        ltime_d = '0;
      end else begin
        ltime_d = (dark_q == dark_d) ? tsat : 32'(delta_q);
        dtime_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q       <= dsfc_pkg::SEQ_IDLE;
    end else begin
      seq_q       <= seq_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= dsfc_pkg::MODE_IDLE;
      str_q       <= '0;
      acc_q       <= dsfc_pkg::AccReset;
      dtime_q     <= '0;
      ltime_q     <= '0;
      seen_q      <= 1'b0;
      dark_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      mode_q      <= mode_d;
      str_q       <= str_d;
      acc_q       <= acc_d;
      dtime_q     <= dtime_d;
      ltime_q     <= ltime_d;
      seen_q      <= seen_d;
      dark_q      <= dark_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    delta_q <= delta_d;
    luma_q  <= luma_d;
    prod_q  <= prod_d;
    out_q   <= out_d;
  end

  assign in_stall_o  = (seq_q != dsfc_pkg::SEQ_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_acc_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_q <= dsfc_pkg::AccReset)
    else $error("smoothed luma above full scale");

  a_str_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    str_q <= dsfc_pkg::FullQ16)
    else $error("strength above full");

  a_active_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q == dsfc_pkg::MODE_ACTIVE |-> str_q == dsfc_pkg::FullQ16)
    else $error("active mode without full strength");

  a_idle_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == dsfc_pkg::MODE_IDLE || mode_q == dsfc_pkg::MODE_WAIT) |-> str_q == '0)
    else $error("idle or waiting with nonzero strength");

  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> seq_q == dsfc_pkg::SEQ_DIV)
    else $error("divider finished outside divide step");
`endif

endmodule
`default_nettype wire

>>> dv/dark_scene_fade_controller_tb.sv
// Testbench for dark_scene_fade_controller: directed and random frame beats
// are checked against a built-in model of the fade controller.
// Depends on dsfc_pkg and the controller RTL.
`timescale 1ns / 100ps
module dark_scene_fade_controller_tb;

  logic                         clk_i = 1'b0;
  logic                         rst_ni;
  logic                         in_valid_i;
  logic                         in_stall_o;
  dsfc_pkg::in_beat_t           in_data_i;
  logic                         out_valid_o;
  logic                         out_stall_i;
  dsfc_pkg::out_beat_t          out_data_o;
  logic                         cfg_valid_i;
  logic                         cfg_ready_o;
  logic [dsfc_pkg::CfgIdxW-1:0] cfg_index_i;
  logic [dsfc_pkg::TimeW-1:0]   cfg_data_i;

  dark_scene_fade_controller dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // register shadows and controller state
  logic [dsfc_pkg::LumaW-1:0] thr_cfg;
  logic [dsfc_pkg::TimeW-1:0] hold_cfg;
  logic [dsfc_pkg::TimeW-1:0] fade_in_cfg;
  logic [dsfc_pkg::TimeW-1:0] fade_out_cfg;
  dsfc_pkg::mode_e            exp_mode;
  logic [31:0]                exp_strength;
  logic [31:0]                exp_luma_acc;
  logic [31:0]                exp_dark_us;
  logic [31:0]                exp_light_us;
  bit                         exp_primed;

  dsfc_pkg::out_beat_t pending_fade_results[$];
  dsfc_pkg::out_beat_t got_beat;
  dsfc_pkg::out_beat_t want_beat;

  int err_count = 0;
  int frames_sent = 0;
  int results_checked = 0;
  int cfg_writes = 0;
  int mode_seen [8];
  bit in_gap_on = 1'b0;
  bit stall_on = 1'b0;
  int hold_off_cycles = 0;
  int stall_run = 0;

  task automatic flag_error(string msg);
    $display("ERROR at %0t: %s", $time, msg);
    err_count++;
  endtask

  function automatic void reset_fade_model();
    thr_cfg = dsfc_pkg::ThreshReset;
    hold_cfg = dsfc_pkg::HoldReset;
    fade_in_cfg = dsfc_pkg::FadeInReset;
    fade_out_cfg = dsfc_pkg::FadeOutReset;
    exp_mode = dsfc_pkg::MODE_IDLE;
    exp_strength = '0;
    exp_luma_acc = {4'd0, dsfc_pkg::AccReset};
    exp_dark_us = '0;
    exp_light_us = '0;
    exp_primed = 1'b0;
  endfunction

  function automatic logic [31:0] ramp_q16(logic [dsfc_pkg::DeltaW-1:0] delta,
                                           logic [dsfc_pkg::TimeW-1:0] fade);
    logic [63:0] f;
    logic [63:0] num;
    logic [63:0] q;
    f = {38'd0, fade};
    if (fade < dsfc_pkg::MinFade) f = {38'd0, dsfc_pkg::MinFade};
    num = {28'd0, delta, 16'd0} + (f >> 1);
    q = num / f;
    return q[31:0];
  endfunction

  function automatic logic [31:0] sat_sum(logic [31:0] a, logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic dsfc_pkg::out_beat_t next_fade_result(dsfc_pkg::in_beat_t b);
    logic [31:0]         d;
    logic [31:0]         tgt;
    logic [31:0]         s;
    logic [31:0]         step;
    logic [63:0]         mix;
    logic [63:0]         weight;
    logic                dk;
    logic                dark_met;
    logic                light_met;
    dsfc_pkg::out_beat_t r;
    d = {12'd0, b.delta_us};
    if (d == 0) d = {12'd0, dsfc_pkg::DefaultDelta};
    tgt = {4'd0, b.frame_luma, 16'd0};
    if (!exp_primed) begin
      exp_luma_acc = tgt;
      exp_primed = 1'b1;
    end else begin
      weight = {50'd0, dsfc_pkg::SmoothW};
      mix = {32'd0, exp_luma_acc} * (64'd65536 - weight) + {32'd0, tgt} * weight + 64'd32768;
      exp_luma_acc = mix[47:16];
    end
    dk = exp_luma_acc <= {4'd0, thr_cfg, 16'd0};
    if (dk) begin
      exp_dark_us = sat_sum(exp_dark_us, d);
      exp_light_us = '0;
    end else begin
      exp_light_us = sat_sum(exp_light_us, d);
      exp_dark_us = '0;
    end
    dark_met = (hold_cfg == 0) || (exp_dark_us >= {6'd0, hold_cfg});
    light_met = (hold_cfg == 0) || (exp_light_us >= {6'd0, hold_cfg});
    case (exp_mode)
      dsfc_pkg::MODE_WAIT: begin
        if (!dk) begin
          exp_mode = dsfc_pkg::MODE_IDLE;
          exp_dark_us = '0;
        end else if (dark_met) begin
          exp_mode = dsfc_pkg::MODE_FIN;
        end
      end
      dsfc_pkg::MODE_FIN: begin
        if (!dk) begin
          if (light_met) exp_mode = dsfc_pkg::MODE_FOUT;
        end else begin
          s = exp_strength + ramp_q16(d[dsfc_pkg::DeltaW-1:0], fade_in_cfg);
          if (s > dsfc_pkg::FullQ16) s = 32'(dsfc_pkg::FullQ16);
          exp_strength = s;
          if (s >= dsfc_pkg::SnapHigh) begin
            exp_strength = 32'(dsfc_pkg::FullQ16);
            exp_mode = dsfc_pkg::MODE_ACTIVE;
          end
        end
      end
      dsfc_pkg::MODE_ACTIVE: begin
        exp_strength = 32'(dsfc_pkg::FullQ16);
        if (!dk && light_met) exp_mode = dsfc_pkg::MODE_FOUT;
      end
      dsfc_pkg::MODE_FOUT: begin
        if (dk && dark_met) begin
          exp_mode = dsfc_pkg::MODE_FIN;
        end else begin
          step = ramp_q16(d[dsfc_pkg::DeltaW-1:0], fade_out_cfg);
          exp_strength = (exp_strength > step) ? exp_strength - step : '0;
          if (exp_strength <= dsfc_pkg::SnapLow) begin
            exp_strength = '0;
            exp_mode = dsfc_pkg::MODE_IDLE;
          end
        end
      end
      default: begin
        exp_strength = '0;
        exp_mode = dsfc_pkg::MODE_IDLE;
        if (dk) exp_mode = dark_met ? dsfc_pkg::MODE_FIN : dsfc_pkg::MODE_WAIT;
      end
    endcase
    r.strength = exp_strength[dsfc_pkg::StrW-1:0];
    r.mode = exp_mode;
    r.smoothed_luma = exp_luma_acc[dsfc_pkg::AccW-1:dsfc_pkg::FracW];
    r.dark_flag = dk;
    return r;
  endfunction

  // mostly short gaps, a few long ones
  function automatic int pick_gap(bit on);
    int r;
    if (!on) return 0;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(20, 120);
  endfunction

  task automatic send_frame(logic [dsfc_pkg::DeltaW-1:0] delta,
                            logic [dsfc_pkg::LumaW-1:0] luma);
    int                 gap;
    dsfc_pkg::in_beat_t b;
    b.delta_us = delta;
    b.frame_luma = luma;
    gap = pick_gap(in_gap_on);
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_data_i = b;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    pending_fade_results.push_back(next_fade_result(b));
    frames_sent++;
    @(negedge clk_i);
  endtask

  task automatic drain_block();
    in_valid_i = 1'b0;
    while (pending_fade_results.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(dsfc_pkg::cfg_idx_e idx, logic [dsfc_pkg::TimeW-1:0] val);
    cfg_index_i = idx;
    cfg_data_i = val;
    cfg_valid_i = 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      dsfc_pkg::CFG_THRESH:   thr_cfg = val[dsfc_pkg::LumaW-1:0];
      dsfc_pkg::CFG_HOLD:     hold_cfg = val;
      dsfc_pkg::CFG_FADE_IN:  fade_in_cfg = val;
      dsfc_pkg::CFG_FADE_OUT: fade_out_cfg = val;
      default: ;
    endcase
    cfg_writes++;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // receiver: random stalls plus an optional long hold-off
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off_cycles > 0) begin
        out_stall_i = 1'b1;
        hold_off_cycles--;
      end else begin
        if (stall_run == 0 && stall_on && $urandom_range(0, 2) == 0) stall_run = pick_gap(1'b1);
        out_stall_i = (stall_run > 0);
        if (stall_run > 0) stall_run--;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got_beat = out_data_o;
      if (pending_fade_results.size() == 0) begin
        flag_error("result beat with nothing pending");
      end else begin
        want_beat = pending_fade_results.pop_front();
        results_checked++;
        mode_seen[want_beat.mode]++;
        if (got_beat.strength !== want_beat.strength)
          flag_error($sformatf("result %0d strength got %0d expected %0d",
                               results_checked, got_beat.strength, want_beat.strength));
        if (got_beat.mode !== want_beat.mode)
          flag_error($sformatf("result %0d mode got %0d expected %0d",
                               results_checked, got_beat.mode, want_beat.mode));
        if (got_beat.smoothed_luma !== want_beat.smoothed_luma)
          flag_error($sformatf("result %0d smoothed luma got %0d expected %0d", results_checked,
                               got_beat.smoothed_luma, want_beat.smoothed_luma));
        if (got_beat.dark_flag !== want_beat.dark_flag)
          flag_error($sformatf("result %0d dark flag got %0d expected %0d",
                               results_checked, got_beat.dark_flag, want_beat.dark_flag));
      end
    end
  end

  // first frame loads the average, zero delta, full-range delta, wait, fade-in, fade-out and idle modes
  task automatic test_first_frame();
    send_frame('0, '0);
    send_frame(20'hFFFFF, 12'hFFF);
    send_frame(20'hFFFFF, 12'hFFF);
    send_frame(20'hFFFFF, 12'hFFF);
    drain_block();
  endtask

  // zero hold switches at once; fade times below the floor
  task automatic test_immediate_hold();
    write_reg(dsfc_pkg::CFG_HOLD, '0);
    write_reg(dsfc_pkg::CFG_FADE_IN, '0);
    write_reg(dsfc_pkg::CFG_FADE_OUT, 26'd99);
    write_reg(dsfc_pkg::CFG_THRESH, 26'd4095);
    send_frame(20'd100, 12'hFFF);
    send_frame('0, 12'd2048);
    drain_block();
    write_reg(dsfc_pkg::CFG_THRESH, '0);
    send_frame(20'd1, 12'hFFF);
    send_frame(20'd1, '0);
    send_frame(20'hFFFFF, '0);
    drain_block();
  endtask

  // strength landing just below and on the full and empty snap points
  task automatic test_snap_points();
    write_reg(dsfc_pkg::CFG_THRESH, 26'd4095);
    write_reg(dsfc_pkg::CFG_FADE_IN, 26'd1000000);
    write_reg(dsfc_pkg::CFG_FADE_OUT, 26'd1000000);
    send_frame(20'd16667, 12'd1000);
    send_frame(20'd999894, 12'd1000);
    send_frame(20'd15, 12'd1000);
    drain_block();
    write_reg(dsfc_pkg::CFG_THRESH, '0);
    send_frame(20'd16667, 12'hFFF);
    send_frame(20'd999818, 12'hFFF);
    send_frame(20'd92, 12'hFFF);
    drain_block();
  endtask

  // receiver holds off while frames keep coming, so the input backs up
  task automatic test_output_backpressure();
    write_reg(dsfc_pkg::CFG_THRESH, 26'd1228);
    write_reg(dsfc_pkg::CFG_HOLD, 26'd20000);
    write_reg(dsfc_pkg::CFG_FADE_IN, 26'd40000);
    write_reg(dsfc_pkg::CFG_FADE_OUT, 26'd40000);
    hold_off_cycles = 600;
    repeat (8)
      send_frame(dsfc_pkg::DeltaW'($urandom_range(0, 40000)),
                 dsfc_pkg::LumaW'($urandom_range(0, 2000)));
    drain_block();
  endtask

  function automatic logic [dsfc_pkg::DeltaW-1:0] frame_delta();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return dsfc_pkg::DeltaW'($urandom_range(8000, 40000));
    if (r < 88) return '0;
    return dsfc_pkg::DeltaW'($urandom_range(0, 20'hFFFFF));
  endfunction

  function automatic logic [dsfc_pkg::LumaW-1:0] scene_luma(bit want_dark);
    if (want_dark) return dsfc_pkg::LumaW'($urandom_range(0, thr_cfg));
    if (thr_cfg == 12'hFFF) return dsfc_pkg::LumaW'($urandom_range(0, 4095));
    return dsfc_pkg::LumaW'($urandom_range(thr_cfg + 1, 4095));
  endfunction

  function automatic logic [dsfc_pkg::TimeW-1:0] pick_span(int typ_max);
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return '0;
    if (r < 16) return dsfc_pkg::TimeW'($urandom_range(1, 99));
    if (r < 22) return dsfc_pkg::TimeW'($urandom_range(0, 60000000));
    return dsfc_pkg::TimeW'($urandom_range(100, typ_max));
  endfunction

  // dark and light scenes of random length under varied settings
  task automatic test_random_scenes();
    logic [dsfc_pkg::TimeW-1:0] v;
    int                         n;
    int                         run;
    bit                         dark_scene;
    for (int p = 0; p < 8; p++) begin
      drain_block();
      in_gap_on = (p % 4 != 3);
      stall_on = (p % 4 != 2);
      v = dsfc_pkg::TimeW'($urandom);
      if (p == 0) begin
        v[dsfc_pkg::LumaW-1:0] = '0;
        write_reg(dsfc_pkg::CFG_THRESH, v);
        write_reg(dsfc_pkg::CFG_HOLD, '0);
        write_reg(dsfc_pkg::CFG_FADE_IN, '0);
        write_reg(dsfc_pkg::CFG_FADE_OUT, '0);
      end else if (p == 1) begin
        v[dsfc_pkg::LumaW-1:0] = 12'hFFF;
        write_reg(dsfc_pkg::CFG_THRESH, v);
        write_reg(dsfc_pkg::CFG_HOLD, 26'd60000000);
        write_reg(dsfc_pkg::CFG_FADE_IN, 26'd60000000);
        write_reg(dsfc_pkg::CFG_FADE_OUT, 26'd60000000);
      end else begin
        v[dsfc_pkg::LumaW-1:0] = dsfc_pkg::LumaW'($urandom_range(200, 3900));
        write_reg(dsfc_pkg::CFG_THRESH, v);
        write_reg(dsfc_pkg::CFG_HOLD, pick_span(300000));
        write_reg(dsfc_pkg::CFG_FADE_IN, pick_span(400000));
        write_reg(dsfc_pkg::CFG_FADE_OUT, pick_span(400000));
      end
      n = 0;
      while (n < 200) begin
        dark_scene = $urandom_range(0, 1);
        run = $urandom_range(1, 30);
        for (int k = 0; k < run && n < 200; k++) begin
          if ($urandom_range(0, 9) == 0)
            send_frame(dsfc_pkg::DeltaW'($urandom_range(0, 20'hFFFFF)),
                       dsfc_pkg::LumaW'($urandom_range(0, 4095)));
          else
            send_frame(frame_delta(), scene_luma(dark_scene));
          n++;
        end
      end
    end
    in_gap_on = 1'b0;
    stall_on = 1'b0;
    drain_block();
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    reset_fade_model();
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (2) @(negedge clk_i);

    test_first_frame();
    test_immediate_hold();
    test_snap_points();
    test_output_backpressure();
    test_random_scenes();

    repeat (60) @(posedge clk_i);
    $display("Covered %0d frames, %0d checked results, %0d register writes",
             frames_sent, results_checked, cfg_writes);
    $display("Results by mode idle/wait/fade-in/active/fade-out: %0d %0d %0d %0d %0d",
             mode_seen[0], mode_seen[1], mode_seen[2], mode_seen[3], mode_seen[4]);
    if (err_count == 0 && pending_fade_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #25ms;
    $display("Timeout with %0d results pending", pending_fade_results.size());
    $display("Some tests failed");
    $finish;
  end

endmodule

>>> filelist.f
design/dsfc_pkg.sv
design/dsfc_div.sv
design/dsfc_cfg.sv
design/dark_scene_fade_controller.sv
dv/dark_scene_fade_controller_tb.sv
